>>> src/pidc_pkg.sv
// Shared types, codes and constants of the implant-decay correlator.
`default_nettype none

package pidc_pkg;

  // Defaults of the top-level parameters
  localparam int GRID_SIZE_DEF = 32;
  localparam int TIME_BITS_DEF = 48;

  // Field widths fixed by the interface
  localparam int TS_W    = 48;
  localparam int GEN_W   = 8;
  localparam int GAP_W   = 32;
  localparam int WIN_W   = 40;
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'd1;

  // Configuration reset values
  localparam logic [GAP_W-1:0] MIN_GAP_RST = 32'd500000;
  localparam logic [WIN_W-1:0] WINDOW_RST  = 40'd6000000000;

  // Clock-reset detection: implant far ahead of an early timestamp
  localparam logic [63:0] RESET_GAP   = 64'd500000000000;
  localparam logic [63:0] RESET_EARLY = 64'd1000000000;

  // Event kinds
  localparam logic [1:0] KIND_IMPLANT = 2'd1;

  // Result condition codes
  localparam logic [3:0] COND_INVALID   = 4'd0;
  localparam logic [3:0] COND_IMPLANT   = 4'd1;
  localparam logic [3:0] COND_BACK2BACK = 4'd2;
  localparam logic [3:0] COND_DECAY_OK  = 4'd3;
  localparam logic [3:0] COND_TOO_LATE  = 4'd4;
  localparam logic [3:0] COND_TOO_SOON  = 4'd5;
  localparam logic [3:0] COND_NO_LIST   = 4'd6;
  localparam logic [3:0] COND_NEGATIVE  = 4'd7;
  localparam logic [3:0] COND_CLK_RESET = 4'd8;

  // One input event
  typedef struct packed {
    logic [1:0]      event_kind;
    logic [5:0]      front_strip;
    logic [5:0]      back_strip;
    logic [TS_W-1:0] timestamp;
    logic            mark_flag;
  } evt_t;

  // One result
  typedef struct packed {
    logic [3:0]       condition;
    logic [TS_W-1:0]  delta_time;
    logic             delta_known;
    logic [GEN_W-1:0] generation;
    logic             marked_list_closed;
  } res_t;

  // Write-back control from the evaluator to the sequencer
  typedef struct packed {
    logic wr_en;
    logic clock_reset;
  } wb_ctl_t;

endpackage

`default_nettype wire

>>> src/pidc_mem.sv
// Pixel table: single write port, one registered read port.
`default_nettype none

module pidc_mem #(
  parameter int AW = 10,
  parameter int DW = 59
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/pidc_eval.sv
// Evaluator: classifies one event against its pixel entry and forms the write-back.
`default_nettype none

module pidc_eval #(
  parameter int GRID_SIZE = pidc_pkg::GRID_SIZE_DEF,
  parameter int TW        = pidc_pkg::TS_W
) (
  input  wire pidc_pkg::evt_t            evt_i,
  input  wire logic                      open_i,
  input  wire logic                      marked_i,
  input  wire logic                      isolated_i,
  input  wire logic [pidc_pkg::GEN_W-1:0] gen_i,
  input  wire logic [TW-1:0]             imp_time_i,
  input  wire logic [pidc_pkg::GAP_W-1:0] min_gap_i,
  input  wire logic [pidc_pkg::WIN_W-1:0] window_i,
  output pidc_pkg::res_t                 res_o,
  output pidc_pkg::wb_ctl_t              wb_o,
  output logic                           open_o,
  output logic                           marked_o,
  output logic                           isolated_o,
  output logic      [pidc_pkg::GEN_W-1:0] gen_o,
  output logic      [TW-1:0]             imp_time_o
);
  import pidc_pkg::*;

  logic          pix_valid;
  logic [TW-1:0] t;
  logic [TW-1:0] diff;
  logic [TW-1:0] back;
  logic          t_lt;
  logic          far_early;

  // Interval arithmetic in the stored time width
  assign pix_valid = (32'(evt_i.front_strip) < GRID_SIZE) &&
                     (32'(evt_i.back_strip) < GRID_SIZE);
  assign t         = evt_i.timestamp[TW-1:0];
  assign diff      = t - imp_time_i;
  assign back      = imp_time_i - t;
  assign t_lt      = t < imp_time_i;
  assign far_early = (64'(back) > RESET_GAP) && (64'(t) < RESET_EARLY);

  // Classify the event and form the new entry
  always_comb begin
    res_o      = '0;
    wb_o       = '0;
    open_o     = open_i;
    marked_o   = marked_i;
    isolated_o = isolated_i;
    gen_o      = gen_i;
    imp_time_o = imp_time_i;

    if (!pix_valid) begin
      res_o.condition = COND_INVALID;
    end else if (evt_i.event_kind == KIND_IMPLANT) begin
      res_o.marked_list_closed = marked_i;
      if (open_i) begin
        res_o.condition   = COND_BACK2BACK;
        res_o.delta_time  = TS_W'(diff);
        res_o.delta_known = 1'b1;
        isolated_o        = !t_lt && (64'(diff) >= 64'(min_gap_i));
      end else begin
        res_o.condition = COND_IMPLANT;
        isolated_o      = 1'b1;
      end
      open_o     = 1'b1;
      imp_time_o = t;
      gen_o      = '0;
      marked_o   = 1'b0;
      wb_o.wr_en = 1'b1;
    end else if (!open_i) begin
      res_o.condition = COND_NO_LIST;
    end else if (t_lt) begin
      if (far_early) begin
        res_o.condition          = COND_CLK_RESET;
        res_o.marked_list_closed = marked_i;
        wb_o.clock_reset         = 1'b1;
      end else begin
        res_o.condition = COND_NEGATIVE;
      end
    end else if (!isolated_i) begin
      res_o.condition = COND_TOO_SOON;
      gen_o           = '0;
      marked_o        = marked_i | evt_i.mark_flag;
      wb_o.wr_en      = 1'b1;
    end else if (64'(diff) >= 64'(window_i)) begin
      res_o.condition          = COND_TOO_LATE;
      res_o.delta_time         = TS_W'(diff);
      res_o.delta_known        = 1'b1;
      res_o.marked_list_closed = marked_i | evt_i.mark_flag;
      open_o                   = 1'b0;
      marked_o                 = 1'b0;
      wb_o.wr_en               = 1'b1;
    end else begin
      // Extend the chain, saturating the generation
      if (gen_i != '1) begin
        gen_o = gen_i + GEN_W'(1);
      end
      res_o.condition   = COND_DECAY_OK;
      res_o.delta_time  = TS_W'(diff);
      res_o.delta_known = 1'b1;
      res_o.generation  = gen_o;
      marked_o          = marked_i | evt_i.mark_flag;
      wb_o.wr_en        = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> src/pixel_implant_decay_correlator.sv
// Top level of the implant-decay correlator: sequencer, configuration and pixel table.
//
// Usage: drive an event on evt_i and raise start; the event is transferred at a
// rising edge where start is high and busy is low. Each event yields exactly one
// result on res_o, marked by res_valid_o for a single cycle; the receiver cannot
// stall it. Configuration registers (0: minimum implant gap, 1: correlation
// window) are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user is to write
// them only while idle, which the block itself does not enforce. At the transfer edge
// the event is captured and its pixel entry is read into the table's read register;
// the execute state then evaluates and writes back the entry and registers the result.
// Busy is high until then, so no new event is taken meanwhile. Reset: busy stays high
// for a clearing pass over all GRID_SIZE*GRID_SIZE pixels (1024 at the default grid)
// that closes and unmarks every pixel; configuration writes are taken meanwhile.
// A clock-reset event runs the same pass, with busy high, once its result is registered.
`default_nettype none

module pixel_implant_decay_correlator #(
  parameter int GRID_SIZE = pidc_pkg::GRID_SIZE_DEF,
  parameter int TIME_BITS = pidc_pkg::TIME_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pidc_pkg::evt_t               evt_i,
  output logic                              res_valid_o,
  output pidc_pkg::res_t                    res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pidc_pkg::CFG_W-1:0]   cfg_data_i
);
  import pidc_pkg::*;

  localparam int NPIX  = GRID_SIZE * GRID_SIZE;
  localparam int PIX_W = $clog2(NPIX);
  localparam int TW    = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
  localparam int ENT_W = TW + GEN_W + 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                 state_q;
  logic [PIX_W-1:0]       sweep_q;
  evt_t                   evt_q;
  logic [PIX_W-1:0]       addr_q;
  res_t                   res_q;
  logic                   res_valid_q;
  logic [GAP_W-1:0]       min_gap_q;
  logic [WIN_W-1:0]       window_q;

  logic                   accept;
  logic [PIX_W-1:0]       addr_in;
  logic                   mem_we;
  logic [PIX_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic [ENT_W-1:0]       mem_rdata;

  res_t                   ev_res;
  wb_ctl_t                ev_wb;
  logic                   nx_open;
  logic                   nx_marked;
  logic                   nx_isolated;
  logic [GEN_W-1:0]       nx_gen;
  logic [TW-1:0]          nx_time;

  // Entry index from the strips
  assign addr_in = PIX_W'(32'(evt_i.front_strip) * GRID_SIZE + 32'(evt_i.back_strip));
  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= MIN_GAP_RST;
      window_q  <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_GAP: min_gap_q <= cfg_data_i[GAP_W-1:0];
        REG_WINDOW:  window_q  <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  pidc_mem #(
    .AW (PIX_W),
    .DW (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (addr_in),
    .rdata_o (mem_rdata)
  );

  pidc_eval #(
    .GRID_SIZE (GRID_SIZE),
    .TW        (TW)
  ) u_eval (
    .evt_i      (evt_q),
    .open_i     (mem_rdata[ENT_W-1]),
    .marked_i   (mem_rdata[ENT_W-2]),
    .isolated_i (mem_rdata[ENT_W-3]),
    .gen_i      (mem_rdata[TW+GEN_W-1:TW]),
    .imp_time_i (mem_rdata[TW-1:0]),
    .min_gap_i  (min_gap_q),
    .window_i   (window_q),
    .res_o      (ev_res),
    .wb_o       (ev_wb),
    .open_o     (nx_open),
    .marked_o   (nx_marked),
    .isolated_o (nx_isolated),
    .gen_o      (nx_gen),
    .imp_time_o (nx_time)
  );

  // Table write port: clearing pass or write-back
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == ST_EXEC) && ev_wb.wr_en;
      mem_waddr = addr_q;
      mem_wdata = {nx_open, nx_marked, nx_isolated, nx_gen, nx_time};
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q  <= evt_i;
      addr_q <= addr_in;
    end
  end

  // Sequencer: clear, wait for a transfer, evaluate and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (32'(sweep_q) == NPIX - 1) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + PIX_W'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q       <= ev_res;
          res_valid_q <= 1'b1;
          sweep_q     <= '0;
          state_q     <= ev_wb.clock_reset ? ST_CLEAR : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the pixel implant-decay correlator.
`default_nettype none

module tb;
  import pidc_pkg::*;

  localparam int PIX_GRID    = GRID_SIZE_DEF;
  localparam int PIX_COUNT   = PIX_GRID * PIX_GRID;
  localparam int STALL_LIMIT = 5000;
  localparam int SEG_ITEMS   = 230;

  // Non-implant kinds, all handled as decays
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_DECAY   = 2'd2;
  localparam logic [1:0] KIND_GAMMA   = 2'd3;

  // Tracks the pixel table and predicts the outcome of every transferred event
  class correlation_tracker;
    bit          pix_open [PIX_COUNT];
    logic [47:0] pix_time [PIX_COUNT];
    bit          pix_isol [PIX_COUNT];
    logic [7:0]  pix_gen  [PIX_COUNT];
    bit          pix_mark [PIX_COUNT];
    logic [31:0] min_gap;
    logic [39:0] window;
    res_t        pending_outcomes[$];
    int          errors;
    int          events;
    int          cond_hits[16];

    function new();
      foreach (pix_open[i]) begin
        pix_open[i] = 1'b0;
        pix_mark[i] = 1'b0;
        pix_time[i] = '0;
        pix_isol[i] = 1'b0;
        pix_gen[i]  = '0;
      end
      foreach (cond_hits[i]) cond_hits[i] = 0;
      min_gap = MIN_GAP_RST;
      window  = WINDOW_RST;
      errors  = 0;
      events  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_MIN_GAP) min_gap = data[GAP_W-1:0];
      else window = data[WIN_W-1:0];
    endfunction

    function void correlate_event(evt_t e);
      res_t        r;
      int unsigned p;
      logic [47:0] t;
      logic [47:0] prev;
      logic [47:0] d;
      logic [7:0]  g;
      r = '0;
      t = e.timestamp;
      events++;
      if (e.front_strip >= PIX_GRID || e.back_strip >= PIX_GRID) begin
        r.condition = COND_INVALID;
      end else begin
        p = e.front_strip * PIX_GRID + e.back_strip;
        if (e.event_kind == KIND_IMPLANT) begin
          // Reopen the pixel; discard any marked list
          r.marked_list_closed = pix_mark[p];
          if (pix_open[p]) begin
            prev = pix_time[p];
            d = t - prev;
            pix_isol[p] = (t >= prev) && (d >= min_gap);
            r.condition   = COND_BACK2BACK;
            r.delta_time  = d;
            r.delta_known = 1'b1;
          end else begin
            pix_isol[p] = 1'b1;
            r.condition = COND_IMPLANT;
          end
          pix_open[p] = 1'b1;
          pix_time[p] = t;
          pix_gen[p]  = '0;
          pix_mark[p] = 1'b0;
        end else if (!pix_open[p]) begin
          r.condition = COND_NO_LIST;
        end else if (t < pix_time[p]) begin
          // Early timestamp far behind the implant means the clock restarted
          if ((pix_time[p] - t) > RESET_GAP && t < RESET_EARLY) begin
            r.condition = COND_CLK_RESET;
            r.marked_list_closed = pix_mark[p];
            foreach (pix_open[i]) begin
              pix_open[i] = 1'b0;
              pix_mark[i] = 1'b0;
            end
          end else begin
            r.condition = COND_NEGATIVE;
          end
        end else begin
          d = t - pix_time[p];
          if (!pix_isol[p]) begin
            pix_gen[p] = '0;
            if (e.mark_flag) pix_mark[p] = 1'b1;
            r.condition = COND_TOO_SOON;
          end else if (d >= window) begin
            r.condition   = COND_TOO_LATE;
            r.delta_time  = d;
            r.delta_known = 1'b1;
            r.marked_list_closed = pix_mark[p] | e.mark_flag;
            pix_open[p] = 1'b0;
            pix_mark[p] = 1'b0;
          end else begin
            // Extend the chain, saturating the generation
            g = pix_gen[p];
            if (g != 8'hFF) g = g + 8'd1;
            pix_gen[p] = g;
            if (e.mark_flag) pix_mark[p] = 1'b1;
            r.condition   = COND_DECAY_OK;
            r.delta_time  = d;
            r.delta_known = 1'b1;
            r.generation  = g;
          end
        end
      end
      pending_outcomes.insert(pending_outcomes.size(), r);
    endfunction

    function void check_outcome(res_t got);
      res_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no event outstanding: condition %0d", got.condition);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      cond_hits[want.condition]++;
      if (got.condition !== want.condition) begin
        $error("condition: expected %0d, got %0d", want.condition, got.condition);
        errors++;
      end
      if (got.delta_time !== want.delta_time) begin
        $error("delta_time: expected %0d, got %0d", want.delta_time, got.delta_time);
        errors++;
      end
      if (got.delta_known !== want.delta_known) begin
        $error("delta_known: expected %0d, got %0d", want.delta_known, got.delta_known);
        errors++;
      end
      if (got.generation !== want.generation) begin
        $error("generation: expected %0d, got %0d", want.generation, got.generation);
        errors++;
      end
      if (got.marked_list_closed !== want.marked_list_closed) begin
        $error("marked_list_closed: expected %0d, got %0d",
               want.marked_list_closed, got.marked_list_closed);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  evt_t                 evt;
  logic                 res_valid;
  res_t                 res;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  correlation_tracker tracker;
  int          idle_pct;
  int          stall_cycles;
  logic [47:0] t_now;
  logic [63:0] step_scale;
  logic [5:0]  hot_fs[6];
  logic [5:0]  hot_bs[6];

  pixel_implant_decay_correlator uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .evt_i      (evt),
    .res_valid_o(res_valid),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result strobe at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && res_valid) tracker.check_outcome(res);
  end

  // Abort when neither side has made a transfer for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles", stall_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic evt_t make_event(logic [1:0] kind, logic [5:0] fs, logic [5:0] bs,
                                      logic [47:0] ts, logic mark);
    evt_t e;
    e.event_kind  = kind;
    e.front_strip = fs;
    e.back_strip  = bs;
    e.timestamp   = ts;
    e.mark_flag   = mark;
    return e;
  endfunction

  function automatic logic [1:0] other_kind();
    case ($urandom_range(2))
      0:       return KIND_UNKNOWN;
      1:       return KIND_DECAY;
      default: return KIND_GAMMA;
    endcase
  endfunction

  // Mostly the hot pixels, so that lists build up; sometimes any valid pixel
  function automatic logic [11:0] pick_pixel();
    int k;
    k = $urandom_range(5);
    if ($urandom_range(99) < 85) return {hot_fs[k], hot_bs[k]};
    return {6'($urandom_range(PIX_GRID - 1)), 6'($urandom_range(PIX_GRID - 1))};
  endfunction

  // Advance the timeline by a step scaled to the current window
  function automatic logic [47:0] advance_time();
    logic [63:0] r;
    r = rand64();
    if ($urandom_range(99) < 85) t_now = t_now + 48'(r % (step_scale + 1));
    else t_now = t_now + 48'(r % (step_scale * 8 + 1));
    return t_now;
  endfunction

  // Hold start until the event is transferred, idling first at random
  task automatic send_event(input evt_t e);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    evt   <= e;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.correlate_event(e);
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending_outcomes.size() != 0);
  endtask

  // Write both registers; junk above the gap width must be dropped
  task automatic write_regs(input logic [31:0] gap, input logic [39:0] win);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_MIN_GAP;
    cfg_data <= {8'($urandom), gap};
    @(posedge clk);
    tracker.write_reg(REG_MIN_GAP, {8'd0, gap});
    cfg_idx  <= REG_WINDOW;
    cfg_data <= win;
    @(posedge clk);
    tracker.write_reg(REG_WINDOW, win);
    cfg_we <= 1'b0;
  endtask

  // Open a pixel and follow it with a run of closely spaced decays
  task automatic decay_chain(input int len, input logic [5:0] fs, input logic [5:0] bs);
    send_event(make_event(KIND_IMPLANT, fs, bs, advance_time(), 1'b0));
    repeat (len) begin
      t_now = t_now + 48'($urandom_range(0, 7));
      send_event(make_event(other_kind(), fs, bs, t_now, $urandom_range(7) == 0));
    end
  endtask

  initial begin
    int          pick;
    int          sent;
    int          len;
    logic [11:0] pix;
    logic [63:0] r64;
    logic [31:0] gap;
    logic [39:0] win;
    logic [47:0] ts;

    tracker  = new();
    idle_pct = 32;
    t_now    = '0;
    step_scale = 64'd3000;
    foreach (hot_fs[i]) begin
      hot_fs[i] = 6'($urandom_range(PIX_GRID - 2));
      hot_bs[i] = 6'($urandom_range(PIX_GRID - 2));
    end
    rst_n    <= 1'b0;
    start    <= 1'b0;
    evt      <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_MIN_GAP;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small gap and window so each outcome is easy to reach
    write_regs(32'd1000, 40'd100000);
    send_event(make_event(KIND_DECAY, 6'd0, 6'd0, 48'd0, 1'b0));          // no list
    send_event(make_event(KIND_IMPLANT, 6'd32, 6'd0, 48'd5, 1'b0));        // invalid front
    send_event(make_event(KIND_DECAY, 6'd0, 6'd63, 48'hFFFF_FFFF_FFFF, 1'b1));
    send_event(make_event(KIND_IMPLANT, 6'd31, 6'd31, 48'd100, 1'b0));
    send_event(make_event(KIND_DECAY, 6'd31, 6'd31, 48'd150, 1'b1));       // marks list
    send_event(make_event(KIND_GAMMA, 6'd31, 6'd31, 48'd200, 1'b0));
    send_event(make_event(KIND_UNKNOWN, 6'd31, 6'd31, 48'd250, 1'b0));
    send_event(make_event(KIND_DECAY, 6'd31, 6'd31, 48'd50, 1'b0));        // negative
    send_event(make_event(KIND_IMPLANT, 6'd31, 6'd31, 48'd300, 1'b0));    // back to back
    send_event(make_event(KIND_DECAY, 6'd31, 6'd31, 48'd400, 1'b1));       // too soon
    send_event(make_event(KIND_IMPLANT, 6'd31, 6'd31, 48'd5000, 1'b0));   // isolated again
    send_event(make_event(KIND_DECAY, 6'd31, 6'd31, 48'd105000, 1'b0));    // at the window
    send_event(make_event(KIND_IMPLANT, 6'd0, 6'd31, 48'hFFFF_FFFF_FFFF, 1'b0));
    send_event(make_event(KIND_IMPLANT, 6'd0, 6'd31, 48'd10, 1'b0));      // wrapped interval
    send_event(make_event(KIND_IMPLANT, 6'd1, 6'd2, 48'd2000000000000, 1'b0));
    send_event(make_event(KIND_DECAY, 6'd1, 6'd2, 48'd2000000000005, 1'b1));
    send_event(make_event(KIND_DECAY, 6'd1, 6'd2, 48'd999999999, 1'b0));   // clock restart
    send_event(make_event(KIND_DECAY, 6'd1, 6'd2, 48'd3000000000000, 1'b0));
    send_event(make_event(KIND_IMPLANT, 6'd2, 6'd2, 48'd2000000000000, 1'b0));
    send_event(make_event(KIND_DECAY, 6'd2, 6'd2, 48'd1000000000, 1'b0));  // not early enough
    send_event(make_event(KIND_IMPLANT, 6'd4, 6'd4, 48'd500000000010, 1'b0));
    send_event(make_event(KIND_DECAY, 6'd4, 6'd4, 48'd10, 1'b0));          // gap not exceeded

    // Random segments, each under its own register setting
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      case (seg)
        0: begin
          gap = 32'd1000; win = 40'd100000; step_scale = 64'd3000;
        end
        1: begin
          gap = 32'd0; win = 40'hFF_FFFF_FFFF; step_scale = 64'd1 << 30;
        end
        2: begin
          gap = 32'hFFFF_FFFF; win = 40'd0; step_scale = 64'd1 << 20;
          idle_pct = 67;
        end
        3: begin
          r64 = rand64();
          gap = $urandom(); win = r64[39:0]; step_scale = {24'd0, r64[39:0]} >> 3;
        end
        4: begin
          gap = MIN_GAP_RST; win = WINDOW_RST; step_scale = 64'd1000000000;
          idle_pct = 0;
        end
        default: begin
          gap = $urandom_range(0, 5000); win = 40'($urandom_range(1, 200000));
          step_scale = {24'd0, win} / 4 + 1;
        end
      endcase
      write_regs(gap, win);
      // Drive one pixel past the generation ceiling while the window is widest
      if (seg == 1) decay_chain(260, 6'd31, 6'd31);
      sent = 0;
      while (sent < SEG_ITEMS) begin
        pick = $urandom_range(99);
        pix  = pick_pixel();
        if (pick < 2) begin
          // Late implant then an early decay: the clock restarted
          t_now = 48'd600000000000 + 48'($urandom);
          send_event(make_event(KIND_IMPLANT, pix[11:6], pix[5:0], t_now, 1'b0));
          t_now = 48'($urandom_range(0, 999999999));
          send_event(make_event(KIND_DECAY, pix[11:6], pix[5:0], t_now,
                                $urandom_range(1) == 1));
          sent += 2;
        end else if (pick < 7) begin
          len = $urandom_range(2, 10);
          decay_chain(len, pix[11:6], pix[5:0]);
          sent += len + 1;
        end else if (pick < 8) begin
          drain();
        end else if (pick < 18) begin
          // Noise across the whole field ranges
          r64 = rand64();
          send_event(make_event(2'($urandom_range(3)), 6'($urandom_range(63)),
                                6'($urandom_range(63)), r64[47:0], $urandom_range(1) == 1));
          sent++;
        end else begin
          if ($urandom_range(9) == 0) ts = t_now - 48'(rand64() % (step_scale + 1));
          else ts = advance_time();
          send_event(make_event(($urandom_range(9) < 3) ? KIND_IMPLANT : other_kind(),
                                pix[11:6], pix[5:0], ts, $urandom_range(1) == 1));
          sent++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d events: directed cases, then six register settings at three idle rates",
             tracker.events);
    $display("By condition: invalid %0d implant %0d b2b %0d ok %0d late %0d soon %0d",
             tracker.cond_hits[COND_INVALID], tracker.cond_hits[COND_IMPLANT],
             tracker.cond_hits[COND_BACK2BACK], tracker.cond_hits[COND_DECAY_OK],
             tracker.cond_hits[COND_TOO_LATE], tracker.cond_hits[COND_TOO_SOON]);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
